### hw/rtl/nearest_path_point_finder_defines.svh
// Assertion helpers for the nearest path point finder.
`ifndef NEAREST_PATH_POINT_FINDER_DEFINES_SVH
`define NEAREST_PATH_POINT_FINDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/npf_pkg.sv
package npf_pkg;

    localparam int COORD_W    = 24;
    localparam int ATTR_W     = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 9;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = 25;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [ATTR_W-1:0]  point_yaw;
        logic signed [ATTR_W-1:0]  point_curvature;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] near_y;
        logic signed [ATTR_W-1:0]  near_yaw;
        logic signed [ATTR_W-1:0]  near_curvature;
        logic [ROOT_W-1:0]         end_distance;
        logic [STATUS_W-1:0]       status;
        logic [OUT_CNT_W-1:0]      point_count;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [ATTR_W-1:0]  yaw;
        logic signed [ATTR_W-1:0]  curvature;
    } t_entry;

    typedef struct packed {
        logic first;
        logic last;
    } t_tag;

endpackage

### hw/rtl/npf_store.sv
module npf_store
    import npf_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  t_entry                        i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  t_tag                          i_rd_tag,
    output logic                          o_rd_valid,
    output t_entry                        o_rd_data,
    output t_tag                          o_rd_tag
);

    t_entry r_mem [MAX_POINTS];
    t_entry r_rd_data;
    t_tag   r_rd_tag;
    logic   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_tag  <= i_rd_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_en;
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_data  = r_rd_data;
    assign o_rd_tag   = r_rd_tag;

endmodule

### hw/rtl/npf_dist.sv
module npf_dist
    import npf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_entry                    i_entry,
    input  t_tag                      i_tag,
    input  logic signed [COORD_W-1:0] i_qx,
    input  logic signed [COORD_W-1:0] i_qy,
    output logic                      o_valid,
    output logic [SQ_W-1:0]           o_dist,
    output t_entry                    o_entry,
    output t_tag                      o_tag
);

    logic signed [DIFF_W-1:0] n_dx;
    logic signed [DIFF_W-1:0] n_dy;
    logic [DIFF_W-1:0]        n_ax;
    logic [DIFF_W-1:0]        n_ay;

    logic [DIFF_W-1:0] r_ax;
    logic [DIFF_W-1:0] r_ay;
    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic [SQ_W-1:0]   r_dist;
    t_entry            r_entry1;
    t_entry            r_entry2;
    t_entry            r_entry3;
    t_tag              r_tag1;
    t_tag              r_tag2;
    t_tag              r_tag3;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;

    always_comb begin
        n_dx = {i_entry.x[COORD_W-1], i_entry.x} - {i_qx[COORD_W-1], i_qx};
        n_dy = {i_entry.y[COORD_W-1], i_entry.y} - {i_qy[COORD_W-1], i_qy};
        n_ax = n_dx[DIFF_W-1] ? DIFF_W'(-n_dx) : DIFF_W'(n_dx);
        n_ay = n_dy[DIFF_W-1] ? DIFF_W'(-n_dy) : DIFF_W'(n_dy);
    end

    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_entry1 <= i_entry;
        r_tag1   <= i_tag;
        r_sqx    <= {{DIFF_W{1'b0}}, r_ax} * {{DIFF_W{1'b0}}, r_ax};
        r_sqy    <= {{DIFF_W{1'b0}}, r_ay} * {{DIFF_W{1'b0}}, r_ay};
        r_entry2 <= r_entry1;
        r_tag2   <= r_tag1;
        r_dist   <= r_sqx + r_sqy;
        r_entry3 <= r_entry2;
        r_tag3   <= r_tag2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_dist  = r_dist;
    assign o_entry = r_entry3;
    assign o_tag   = r_tag3;

endmodule

### hw/rtl/npf_isqrt.sv
module npf_isqrt
    import npf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0]   r_rem;
    logic [SQ_W:0]     r_root;
    logic [SQ_W-1:0]   r_bit;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic [SQ_W:0]     n_trial;
    logic              n_take;

    always_comb begin
        n_trial = r_root + {1'b0, r_bit};
        n_take  = {1'b0, r_rem} >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_value;
            r_root <= '0;
            r_bit  <= SQ_W'(1) << (SQ_W - 2);
            r_step <= STEP_W'(SQRT_STEPS - 1);
        end else if (r_busy) begin
            if (n_take) begin
                r_rem  <= r_rem - n_trial[SQ_W-1:0];
                r_root <= (r_root >> 1) + {1'b0, r_bit};
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_step == '0)) begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root[ROOT_W-1:0];

endmodule

### hw/rtl/nearest_path_point_finder.sv
// Nearest path point finder: stores an ordered path and answers nearest-point queries.
// Input channel: i_in_valid / o_in_stall carry one command item (clear, append, query).
// Output channel: o_out_valid / i_out_stall return exactly one result item per command.
// Clear, append and the unused command need no scan: the result is registered at
// the accepting edge and shows on the next cycle. A query on an empty path does the same.
// A query on N stored points reads the point memory once per point, one address a cycle,
// through a three-stage squared-distance pipeline, then runs a 25-step bit-pair square
// root on the distance to the last point. The input stays stalled until the result is
// loaded into the output register; the point memory read port sets the rate at one
// point a cycle.
// One command is in flight at a time; o_in_stall is high while a query runs and while a
// finished result sits in the output register with i_out_stall high.
// A stalled result holds in the output register until taken.
// Reset (i_rst_n low at a clock edge) empties the path and drops any query in progress;
// the point memory itself is not cleared, no clearing pass runs, and the block accepts
// an item in the first cycle after reset.
`include "nearest_path_point_finder_defines.svh"

module nearest_path_point_finder
    import npf_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_SQRT  = 2'd3;

    logic [1:0]                r_state;
    logic [CNT_W-1:0]          r_count;
    logic [ADDR_W-1:0]         r_addr;
    logic [ADDR_W-1:0]         r_last_addr;
    logic signed [COORD_W-1:0] r_qx;
    logic signed [COORD_W-1:0] r_qy;
    logic [SQ_W-1:0]           r_best_d;
    t_entry                    r_best_entry;
    logic                      r_out_valid;
    t_out_item                 r_out_item;

    logic [1:0]                n_state;
    logic [CNT_W-1:0]          n_count;
    logic [ADDR_W-1:0]         n_addr;
    logic [ADDR_W-1:0]         n_last_addr;
    logic signed [COORD_W-1:0] n_qx;
    logic signed [COORD_W-1:0] n_qy;
    logic [SQ_W-1:0]           n_best_d;
    t_entry                    n_best_entry;
    logic                      n_out_valid;
    t_out_item                 n_out_item;

    logic      in_acc;
    logic      out_free;
    logic      out_load;
    logic      wr_en;
    t_entry    wr_data;
    logic      rd_en;
    t_tag      rd_tag;
    logic      mem_valid;
    t_entry    mem_data;
    t_tag      mem_tag;
    logic      d_valid;
    logic [SQ_W-1:0] d_dist;
    t_entry    d_entry;
    t_tag      d_tag;
    logic      sq_start;
    logic      sq_busy;
    logic [ROOT_W-1:0] sq_root;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign wr_data.x         = i_in_item.pos_x;
    assign wr_data.y         = i_in_item.pos_y;
    assign wr_data.yaw       = i_in_item.point_yaw;
    assign wr_data.curvature = i_in_item.point_curvature;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_last_addr  = r_last_addr;
        n_qx         = r_qx;
        n_qy         = r_qy;
        n_best_d     = r_best_d;
        n_best_entry = r_best_entry;
        n_out_item   = r_out_item;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_tag.first = (r_addr == '0);
        rd_tag.last  = (r_addr == r_last_addr);
        sq_start     = 1'b0;

        if (d_valid && (d_tag.first || (d_dist < r_best_d))) begin
            n_best_d     = d_dist;
            n_best_entry = d_entry;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_item        = '0;
                    n_out_item.status = STATUS_OK;
                    out_load          = 1'b1;
                    unique case (i_in_item.command)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_APPEND: begin
                            if (r_count >= CNT_W'(MAX_POINTS)) begin
                                n_out_item.status = STATUS_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_out_item.status = STATUS_EMPTY;
                            end else begin
                                out_load    = 1'b0;
                                n_qx        = i_in_item.pos_x;
                                n_qy        = i_in_item.pos_y;
                                n_addr      = '0;
                                n_last_addr = ADDR_W'(r_count - CNT_W'(1));
                                n_state     = S_SCAN;
                            end
                        end
                        CMD_UNUSED: begin
                            n_count = r_count;
                        end
                    endcase
                    n_out_item.point_count = OUT_CNT_W'(n_count);
                end
            end
            S_SCAN: begin
                rd_en = 1'b1;
                if (rd_tag.last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                if (d_valid && d_tag.last) begin
                    sq_start = 1'b1;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!sq_busy && out_free) begin
                    out_load                  = 1'b1;
                    n_out_item.near_x         = r_best_entry.x;
                    n_out_item.near_y         = r_best_entry.y;
                    n_out_item.near_yaw       = r_best_entry.yaw;
                    n_out_item.near_curvature = r_best_entry.curvature;
                    n_out_item.end_distance   = sq_root;
                    n_out_item.status         = STATUS_OK;
                    n_out_item.point_count    = OUT_CNT_W'(r_count);
                    n_state                   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_last_addr  <= n_last_addr;
        r_qx         <= n_qx;
        r_qy         <= n_qy;
        r_best_d     <= n_best_d;
        r_best_entry <= n_best_entry;
        r_out_item   <= n_out_item;
    end

    npf_store #(
        .MAX_POINTS(MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(r_count)),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .i_rd_tag  (rd_tag),
        .o_rd_valid(mem_valid),
        .o_rd_data (mem_data),
        .o_rd_tag  (mem_tag)
    );

    npf_dist u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(mem_valid),
        .i_entry(mem_data),
        .i_tag  (mem_tag),
        .i_qx   (r_qx),
        .i_qy   (r_qy),
        .o_valid(d_valid),
        .o_dist (d_dist),
        .o_entry(d_entry),
        .o_tag  (d_tag)
    );

    npf_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_value(d_dist),
        .o_busy (sq_busy),
        .o_root (sq_root)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `NPF_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_POINTS), "count above capacity")
    `NPF_ASSERT_IMP(a_last_in_drain, d_valid && d_tag.last, r_state == S_DRAIN,
                    "last point outside drain")
    `NPF_ASSERT_NEXT(a_sqrt_runs, sq_start, sq_busy && (r_state == S_SQRT),
                     "square root did not start")
    `NPF_ASSERT_IMP(a_no_result_in_query, r_state == S_SCAN || r_state == S_DRAIN,
                    !r_out_valid, "result pending during query")

endmodule
